### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define EBD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define EBD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/ebd_pkg.sv
package ebd_pkg;

    localparam int WINDOW    = 15;
    localparam int IDX_W     = 4;
    localparam int SAMPLE_W  = 16;
    localparam int MAG_W     = SAMPLE_W + 1;
    localparam int SUM_W     = 19;
    localparam int ENERGY_W  = 16;
    localparam int AVG_W     = 24;
    localparam int GAIN_W    = 10;
    localparam int THR_W     = 16;
    localparam int BURST_W   = 4;
    localparam int SCALED_W  = AVG_W + GAIN_W - 16;
    localparam int EXCESS_W  = SCALED_W + 1;
    localparam int UPD_W     = AVG_W + 4;

    // floor(sum / WINDOW) by reciprocal, one correction step
    localparam int RECIP_W = SUM_W + 1;
    localparam logic [RECIP_W-1:0] WIN_RECIP = RECIP_W'((64'd1 << SUM_W) / WINDOW);
    localparam logic [SUM_W-1:0]   WIN_CONST = SUM_W'(WINDOW);

    // floor(t / 10) by reciprocal, one correction step
    localparam int TEN_SHIFT = UPD_W;
    localparam int TEN_RECIP_W = UPD_W - 3;
    localparam logic [TEN_RECIP_W-1:0] TEN_RECIP = TEN_RECIP_W'((64'd1 << TEN_SHIFT) / 10);
    localparam logic [UPD_W-1:0]       TEN_CONST = UPD_W'(10);
    localparam logic [UPD_W-1:0]       NINE_CONST = UPD_W'(9);

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN      = 8'd0,
        CFG_MARGIN    = 8'd1,
        CFG_LOUD      = 8'd2,
        CFG_MAX_BURST = 8'd3
    } cfg_index_t;

    localparam logic [GAIN_W-1:0]  GAIN_RESET      = GAIN_W'(282);
    localparam logic [THR_W-1:0]   MARGIN_RESET    = THR_W'(160);
    localparam logic [THR_W-1:0]   LOUD_RESET      = THR_W'(480);
    localparam logic [BURST_W-1:0] MAX_BURST_RESET = BURST_W'(15);

    localparam int OUT_W       = 1 + BURST_W + 3 * ENERGY_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain;
        logic [THR_W-1:0]   margin;
        logic [THR_W-1:0]   loud;
        logic [BURST_W-1:0] max_burst;
    } ebd_cfg_t;

    typedef struct packed {
        logic [ENERGY_W-1:0] running_average;
        logic [ENERGY_W-1:0] frame_energy;
        logic [ENERGY_W-1:0] beat_strength;
        logic [BURST_W-1:0]  burst_count;
        logic                beat;
    } ebd_result_t;

endpackage

### rtl/ebd_frame_math.sv
module ebd_frame_math (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [ebd_pkg::SUM_W-1:0] sum,
    input  ebd_pkg::ebd_cfg_t       cfg,
    output logic                    res_valid,
    output ebd_pkg::ebd_result_t    res,
    output logic                    busy
);
    import ebd_pkg::*;

    logic                    v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [SUM_W-1:0]        sum1_reg, sum2_reg;
    logic [SUM_W-1:0]        q0_2_reg;
    logic [ENERGY_W-1:0]     e3_reg, e4_reg;
    logic [ENERGY_W-1:0]     avg_hi4_reg;
    logic [SCALED_W-1:0]     scaled4_reg;
    logic [UPD_W-1:0]        t4_reg, t5_reg;
    logic [UPD_W-1:0]        q5_reg;
    logic [AVG_W-1:0]        avg_reg;

    logic [SUM_W+RECIP_W-1:0]     prod1;
    logic [SUM_W-1:0]             q0_next;
    logic [SUM_W-1:0]             mulw2;
    logic [SUM_W-1:0]             rem2;
    logic [SUM_W-1:0]             energy_full;
    logic [AVG_W-1:0]             seeded;
    logic [AVG_W+GAIN_W-1:0]      prod_gain;
    logic [UPD_W-1:0]             t_next;
    logic [UPD_W+TEN_RECIP_W-1:0] prod_ten;
    logic [UPD_W-1:0]             mul10;
    logic [UPD_W-1:0]             rem5;
    logic [UPD_W-1:0]             avg_full;
    logic signed [EXCESS_W-1:0]   excess;
    logic [ENERGY_W-1:0]          strength;
    logic                         beat;
    logic [ENERGY_W-7:0]          burst_raw;
    logic [BURST_W-1:0]           burst;

    // stage 1 -> 2: reciprocal estimate of sum / WINDOW
    assign prod1   = SUM_W'(0) + sum1_reg * WIN_RECIP;
    assign q0_next = prod1[SUM_W+RECIP_W-1:SUM_W] > (SUM_W+RECIP_W-SUM_W)'(0)
                     ? SUM_W'(prod1[SUM_W+RECIP_W-1:SUM_W]) : SUM_W'(0);

    // stage 2 -> 3: correct the estimate by at most one
    assign mulw2       = q0_2_reg * WIN_CONST;
    assign rem2        = sum2_reg - mulw2;
    assign energy_full = q0_2_reg + SUM_W'(rem2 >= WIN_CONST);

    // stage 3 -> 4: seed an empty average, scale it and start the update
    assign seeded    = (avg_reg == AVG_W'(0)) ? {e3_reg, 8'd0} : avg_reg;
    assign prod_gain = seeded * cfg.gain;
    assign t_next    = UPD_W'(seeded) * NINE_CONST + UPD_W'({e3_reg, 8'd0});

    // stage 4: beat decision
    assign excess    = $signed({3'd0, e4_reg}) - $signed({1'b0, scaled4_reg});
    always_comb
    begin
        if (excess <= $signed(EXCESS_W'(0)))
            strength = '0;
        else if (excess[EXCESS_W-1:ENERGY_W] != '0)
            strength = '1;
        else
            strength = excess[ENERGY_W-1:0];
    end
    assign beat      = (excess > $signed({3'd0, cfg.margin})) && (e4_reg > cfg.loud);
    assign burst_raw = strength[ENERGY_W-1:6];
    always_comb
    begin
        if (!beat)
            burst = '0;
        else if (burst_raw > (ENERGY_W-6)'(cfg.max_burst))
            burst = cfg.max_burst;
        else
            burst = burst_raw[BURST_W-1:0];
    end

    assign res_valid           = v4_reg;
    assign res.beat            = beat;
    assign res.burst_count     = burst;
    assign res.beat_strength   = strength;
    assign res.frame_energy    = e4_reg;
    assign res.running_average = avg_hi4_reg;

    // stage 4 -> 5: reciprocal estimate of t / 10, then correct in stage 5
    assign prod_ten = t4_reg * TEN_RECIP;
    assign mul10    = q5_reg * TEN_CONST;
    assign rem5     = t5_reg - mul10;
    assign avg_full = q5_reg + UPD_W'(rem5 >= TEN_CONST);

    assign busy = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            avg_reg <= '0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            if (v5_reg)
                avg_reg <= avg_full[AVG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            sum1_reg <= sum;
        sum2_reg    <= sum1_reg;
        q0_2_reg    <= q0_next;
        e3_reg      <= energy_full[ENERGY_W-1:0];
        e4_reg      <= e3_reg;
        avg_hi4_reg <= seeded[AVG_W-1:8];
        scaled4_reg <= prod_gain[AVG_W+GAIN_W-1:16];
        t4_reg      <= t_next;
        t5_reg      <= t4_reg;
        q5_reg      <= UPD_W'(prod_ten[UPD_W+TEN_RECIP_W-1:TEN_SHIFT]);
    end

endmodule

### rtl/energy_beat_detector_core.sv
// A frame's result goes through the frame-math stages and then the output register.
// Throughput: one sample per cycle; a frame-closing sample waits only while the previous
// frame's 5-stage average update is in flight or its result has not been taken.
// Reset (rst_n low, asynchronous): accumulator, sample count and average cleared,
// configuration set to its defaults, output empty; samples accepted right after.
module energy_beat_detector_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [ebd_pkg::SAMPLE_W-1:0]         s_axis_tdata,   // [15:0] sample
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] beat, [4:1] burst_count, [20:5] beat_strength, [36:21] frame_energy,
    // [52:37] running_average, [55:53] zero
    output logic [ebd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ebd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ebd_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import ebd_pkg::*;

    ebd_cfg_t             cfg_reg;
    logic [SUM_W-1:0]     abs_sum_reg;
    logic [IDX_W-1:0]     sample_index_reg;
    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_data_reg;

    logic [MAG_W-1:0]     mag;
    logic [SUM_W-1:0]     sum_full;
    logic                 closing;
    logic                 accept;
    logic                 start;
    logic                 busy;
    logic                 res_valid;
    ebd_result_t          res;

    assign mag      = s_axis_tdata[SAMPLE_W-1]
                      ? (MAG_W'(1) << SAMPLE_W) - MAG_W'(s_axis_tdata)
                      : MAG_W'(s_axis_tdata);
    assign sum_full = abs_sum_reg + SUM_W'(mag);
    assign closing  = ((IDX_W+1)'(sample_index_reg) + (IDX_W+1)'(1)) >= (IDX_W+1)'(WINDOW);

    // hold a closing sample until the frame pipeline and output slot are free
    assign s_axis_tready = !closing || (!busy && !out_valid_reg);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign start         = accept && closing;

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_data_reg);

    ebd_frame_math u_math (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .sum       (sum_full),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res),
        .busy      (busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain      <= GAIN_RESET;
            cfg_reg.margin    <= MARGIN_RESET;
            cfg_reg.loud      <= LOUD_RESET;
            cfg_reg.max_burst <= MAX_BURST_RESET;
            abs_sum_reg       <= '0;
            sample_index_reg  <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GAIN:      cfg_reg.gain      <= cfg_data[GAIN_W-1:0];
                    CFG_MARGIN:    cfg_reg.margin    <= cfg_data[THR_W-1:0];
                    CFG_LOUD:      cfg_reg.loud      <= cfg_data[THR_W-1:0];
                    CFG_MAX_BURST: cfg_reg.max_burst <= cfg_data[BURST_W-1:0];
                    default:       ;
                endcase
            end
            if (accept)
            begin
                if (closing)
                begin
                    abs_sum_reg      <= '0;
                    sample_index_reg <= '0;
                end
                else
                begin
                    abs_sum_reg      <= sum_full;
                    sample_index_reg <= sample_index_reg + IDX_W'(1);
                end
            end
            if (res_valid)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            out_data_reg <= res;
    end

endmodule

### rtl/ebd_checker.sv
`include "assert_macros.svh"

module ebd_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [ebd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    // hold a stalled request and its payload
    `EBD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `EBD_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    // bursts come only with a beat
    `EBD_ASSERT_IMPL(a_burst_beat, m_axis_tvalid && (m_axis_tdata[4:1] != 4'd0), m_axis_tdata[0])
    // a beat needs a positive excess
    `EBD_ASSERT_IMPL(a_beat_strength, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[20:5] != 16'd0)

endmodule

bind energy_beat_detector_core ebd_checker u_ebd_checker (.*);

### verif/tb.sv
module tb;
    import ebd_pkg::*;

    localparam int RANDOM_ITEMS  = 200;
    localparam int MIN_SCENES    = 6;
    localparam int DRAIN_FRAMES  = 38;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;
    typedef enum {
        SCENE_STEADY, SCENE_SURGE, SCENE_NOISE, SCENE_EXTREME, SCENE_RAGGED, SCENE_HUSH
    } scene_kind_t;
    typedef enum {PICK_RESET, PICK_MIN, PICK_MAX, PICK_RANDOM} pick_t;

    class beat_frame_board;
        ebd_cfg_t            regs;
        logic [SUM_W-1:0]    abs_sum;
        logic [IDX_W-1:0]    fill;
        logic [AVG_W-1:0]    avg_level;
        ebd_result_t         expected_frames[$];
        int                  frames_checked;
        int                  errors;

        function new();
            regs.gain      = GAIN_RESET;
            regs.margin    = MARGIN_RESET;
            regs.loud      = LOUD_RESET;
            regs.max_burst = MAX_BURST_RESET;
            abs_sum        = '0;
            fill           = '0;
            avg_level      = '0;
            frames_checked = 0;
            errors         = 0;
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_GAIN:      regs.gain      = value[GAIN_W-1:0];
                CFG_MARGIN:    regs.margin    = value[THR_W-1:0];
                CFG_LOUD:      regs.loud      = value[THR_W-1:0];
                CFG_MAX_BURST: regs.max_burst = value[BURST_W-1:0];
                default:       ;
            endcase
        endfunction

        function void take_sample(logic [SAMPLE_W-1:0] raw);
            logic [MAG_W-1:0]        mag;
            logic [ENERGY_W-1:0]     energy;
            logic [AVG_W+GAIN_W-1:0] product;
            logic [UPD_W-1:0]        blend;
            logic [ENERGY_W-1:0]     strength;
            logic [BURST_W-1:0]      burst;
            logic                    beat;
            int                      excess;
            ebd_result_t             want;
            mag = raw[SAMPLE_W-1] ? MAG_W'(17'h10000 - raw) : MAG_W'(raw);
            abs_sum = abs_sum + SUM_W'(mag);
            if (int'(fill) + 1 < WINDOW) begin
                fill = fill + 1'b1;
                return;
            end
            energy  = ENERGY_W'(abs_sum / WINDOW);
            abs_sum = '0;
            fill    = '0;
            // reseed an empty average with this frame's energy
            if (avg_level == '0)
                avg_level = {energy, 8'h00};
            product = avg_level * regs.gain;
            excess  = int'(energy) - int'(product[AVG_W+GAIN_W-1:16]);
            // the scaled average is never negative, so a positive excess stays within 16 bits
            strength = (excess > 0) ? ENERGY_W'(excess) : '0;
            beat     = (excess > int'(regs.margin)) && (energy > regs.loud);
            burst    = '0;
            if (beat)
                burst = ((strength >> 6) > regs.max_burst) ? regs.max_burst
                                                          : BURST_W'(strength >> 6);
            want.beat            = beat;
            want.burst_count     = burst;
            want.beat_strength   = strength;
            want.frame_energy    = energy;
            want.running_average = avg_level[AVG_W-1:8];
            blend     = UPD_W'(avg_level) * 9 + UPD_W'({energy, 8'h00});
            avg_level = AVG_W'(blend / 10);
            expected_frames.push_back(want);
        endfunction

        task compare_field(string field, logic [ENERGY_W-1:0] got, logic [ENERGY_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("frame %0d %s: got 0x%0h, want 0x%0h",
                                          frames_checked, field, got, want));
        endtask

        task check_frame(logic [OUT_TDATA_W-1:0] data);
            ebd_result_t got;
            ebd_result_t want;
            got = data[OUT_W-1:0];
            if (expected_frames.size() == 0) begin
                report_mismatch("result with no frame pending");
                return;
            end
            want = expected_frames.pop_front();
            compare_field("beat", got.beat, want.beat);
            compare_field("burst_count", got.burst_count, want.burst_count);
            compare_field("beat_strength", got.beat_strength, want.beat_strength);
            compare_field("frame_energy", got.frame_energy, want.frame_energy);
            compare_field("running_average", got.running_average, want.running_average);
            compare_field("padding", data[OUT_TDATA_W-1:OUT_W], '0);
            frames_checked++;
        endtask
    endclass

    logic                    clk;
    logic                    rst_n         = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [SAMPLE_W-1:0]     s_axis_tdata  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    cfg_valid     = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index     = '0;
    logic [CFG_DATA_W-1:0]   cfg_data      = '0;

    beat_frame_board frame_board = new();

    rx_mode_t    rx_mode     = RX_RANDOM;
    logic [15:0] rx_mask     = 16'hFFFF;
    int          rx_hold     = 0;
    bit          gappy       = 1'b1;
    int          burst_left  = 0;
    int          sent_count  = 0;
    int          cfg_writes  = 0;
    int          cycle_count = 0;

    energy_beat_detector_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic push_sample(input logic [SAMPLE_W-1:0] smp);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        @(posedge clk);
        // hold the request until tready
        while (!s_axis_tready)
            @(posedge clk);
        frame_board.take_sample(smp);
        sent_count++;
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            burst_left = $urandom_range(0, 24);
            gap = gappy ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        frame_board.set_register(idx, value);
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // drop valid, drain expected frames, then let the average update settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (frame_board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] level_sample(int level);
        int mag;
        mag = level + int'($urandom_range(0, level / 4 + 1));
        if (mag > 32767)
            mag = 32767;
        return ($urandom_range(0, 1) != 0) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
    endfunction

    function automatic logic [SAMPLE_W-1:0] tiny_sample();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return 16'h0001;
            default: return 16'hFFFF;
        endcase
    endfunction

    // fourteen tiny samples and a zero keep the frame energy at zero
    task automatic hush_frame();
        repeat (WINDOW - 1) push_sample(tiny_sample());
        push_sample('0);
    endtask

    task automatic play_frames(input int level, input int count);
        repeat (count * WINDOW) push_sample(level_sample(level));
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_setting(cfg_index_t idx, pick_t style);
        int                    width;
        logic [CFG_DATA_W-1:0] value;
        logic [CFG_DATA_W-1:0] top;
        case (idx)
            CFG_GAIN:      width = GAIN_W;
            CFG_MAX_BURST: width = BURST_W;
            default:       width = THR_W;
        endcase
        case (style)
            PICK_MIN: value = '0;
            PICK_MAX: value = CFG_DATA_W'((1 << width) - 1);
            PICK_RESET:
                case (idx)
                    CFG_GAIN:   value = CFG_DATA_W'(GAIN_RESET);
                    CFG_MARGIN: value = CFG_DATA_W'(MARGIN_RESET);
                    CFG_LOUD:   value = CFG_DATA_W'(LOUD_RESET);
                    default:    value = CFG_DATA_W'(MAX_BURST_RESET);
                endcase
            default:
                if (width == THR_W && $urandom_range(0, 3) != 0)
                    value = CFG_DATA_W'($urandom_range(0, 1500));
                else
                    value = CFG_DATA_W'($urandom_range(0, (1 << width) - 1));
        endcase
        // set junk above the register width; the block must drop it
        if (width < CFG_DATA_W) begin
            top   = CFG_DATA_W'($urandom) << width;
            value = value | top;
        end
        return value;
    endfunction

    task automatic retune(input int round);
        pick_t style;
        wait_idle();
        for (int r = 0; r < 4; r++) begin
            if (round == 0)
                style = PICK_MAX;
            else if (round == 1)
                style = PICK_MIN;
            else
                style = pick_t'($urandom_range(0, 3));
            write_reg(CFG_IDX_W'(r), pick_setting(cfg_index_t'(r), style));
        end
        if ($urandom_range(0, 1) != 0)
            write_reg(CFG_IDX_W'(CFG_MAX_BURST) + CFG_IDX_W'($urandom_range(1, 252)),
                      CFG_DATA_W'($urandom));
    endtask

    task automatic play_scene(input scene_kind_t kind);
        int base;
        case (kind)
            SCENE_STEADY: begin
                base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30000)
                                                   : $urandom_range(0, 2500);
                play_frames(base, $urandom_range(1, 4));
            end
            SCENE_SURGE: begin
                base = $urandom_range(300, 2000);
                play_frames(base, $urandom_range(1, 3));
                base = base * $urandom_range(2, 10);
                play_frames((base > 32767) ? 32767 : base, 1);
            end
            SCENE_NOISE:
                repeat ($urandom_range(5, 30)) push_sample(SAMPLE_W'($urandom));
            SCENE_EXTREME:
                repeat (WINDOW)
                    case ($urandom_range(0, 3))
                        0:       push_sample(16'h8000);
                        1:       push_sample(16'h7FFF);
                        2:       push_sample(16'h8001);
                        default: push_sample('0);
                    endcase
            SCENE_RAGGED:
                repeat ($urandom_range(1, WINDOW - 1))
                    push_sample(level_sample($urandom_range(0, 4000)));
            default:
                repeat ($urandom_range(1, 3)) hush_frame();
        endcase
    endtask

    // receiver: check results and stall on its own pattern
    initial
    begin
        int rx_phase;
        rx_phase = 0;
        forever begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                frame_board.check_frame(m_axis_tdata);
            rx_phase++;
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end
            else begin
                case (rx_mode)
                    RX_OPEN:   m_axis_tready <= 1'b1;
                    RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default:   m_axis_tready <= rx_mask[rx_phase % 16];
                endcase
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int          scene_no;
        int          retunes;
        int          directed_items;
        int          roll;
        scene_kind_t kind;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // near-silent frame: energy zero, average seeded with zero
        push_sample('0);
        push_sample(16'hFFFF);
        push_sample(16'h0001);
        repeat (WINDOW - 3) push_sample('0);
        // unit-energy frame seeds a small average
        repeat (WINDOW) push_sample(($urandom_range(0, 1) != 0) ? 16'h0001 : 16'hFFFF);
        // truncation drains the average to zero over silent frames
        repeat (DRAIN_FRAMES) hush_frame();
        // full-scale frame reseeds the empty average
        push_sample(16'h8000);
        push_sample(16'h7FFF);
        repeat (WINDOW - 2) push_sample(($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF);
        wait_idle();
        // junk above the width leaves gain and burst limit at zero
        write_reg(CFG_GAIN, 16'hFC00);
        write_reg(CFG_MAX_BURST, 16'hFFF0);
        write_reg(CFG_IDX_W'(CFG_MAX_BURST) + CFG_IDX_W'(1), 16'hFFFF);
        repeat (WINDOW) push_sample(16'h7FFF);
        wait_idle();
        write_reg(CFG_GAIN, CFG_DATA_W'(GAIN_RESET));
        write_reg(CFG_MARGIN, CFG_DATA_W'(MARGIN_RESET));
        write_reg(CFG_LOUD, CFG_DATA_W'(LOUD_RESET));
        write_reg(CFG_MAX_BURST, CFG_DATA_W'(MAX_BURST_RESET));

        directed_items = sent_count;
        scene_no = 0;
        retunes  = 0;
        while (sent_count < directed_items + RANDOM_ITEMS || scene_no < MIN_SCENES) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_mask = 16'($urandom) | 16'h0001;
            gappy   = ($urandom_range(0, 2) != 0);
            if (scene_no > 0 && scene_no % 2 == 0) begin
                retune(retunes);
                retunes++;
            end
            if (scene_no == 3) begin
                // stall the output long enough to back up the input
                rx_hold = HOLD_CYCLES;
                gappy   = 1'b0;
                play_frames($urandom_range(500, 3000), 6);
                wait_idle();
            end
            else begin
                roll = $urandom_range(0, 99);
                if (roll < 30)
                    kind = SCENE_STEADY;
                else if (roll < 60)
                    kind = SCENE_SURGE;
                else if (roll < 70)
                    kind = SCENE_NOISE;
                else if (roll < 78)
                    kind = SCENE_EXTREME;
                else if (roll < 90)
                    kind = SCENE_RAGGED;
                else
                    kind = SCENE_HUSH;
                play_scene(kind);
            end
            scene_no++;
        end

        wait_idle();
        if (frame_board.pending() != 0)
            frame_board.report_mismatch($sformatf("%0d expected frames never arrived",
                                                  frame_board.pending()));
        $display("sent %0d samples (%0d directed), checked %0d frames, %0d register writes",
                 sent_count, directed_items, frame_board.frames_checked, cfg_writes);
        $display("included a %0d-cycle output stall and %0d setting rounds",
                 HOLD_CYCLES, retunes);
        if (frame_board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### energy_beat_detector_core.f
+incdir+rtl
rtl/ebd_pkg.sv
rtl/ebd_frame_math.sv
rtl/energy_beat_detector_core.sv
rtl/ebd_checker.sv
verif/tb.sv
